>>> src/nch_pkg.sv
`timescale 1ns / 1ps

package nch_pkg;

   // Event codes carried by the operation field of an input word.
   localparam logic [2:0] OP_FREQ_TICK   = 3'd0;
   localparam logic [2:0] OP_LENGTH_TICK = 3'd1;
   localparam logic [2:0] OP_ENV_TICK    = 3'd2;
   localparam logic [2:0] OP_WRITE       = 3'd3;
   localparam logic [2:0] OP_READ        = 3'd4;
   localparam logic [2:0] OP_POWER_OFF   = 3'd5;

   // Channel register numbers.
   localparam logic [1:0] REG_LENGTH   = 2'd0;
   localparam logic [1:0] REG_ENVELOPE = 2'd1;
   localparam logic [1:0] REG_POLY     = 2'd2;
   localparam logic [1:0] REG_CONTROL  = 2'd3;

   localparam int unsigned DIV_COUNT   = 8;
   localparam int unsigned DIV_WIDTH   = 8;
   localparam int unsigned SHIFT_WIDTH = 4;
   localparam int unsigned TIMER_WIDTH = 23;
   localparam int unsigned LFSR_WIDTH  = 15;

   localparam logic [TIMER_WIDTH-1:0] TIMER_RESET   = 23'd8;
   localparam logic [LFSR_WIDTH-1:0]  LFSR_SEED     = 15'h7FFF;
   localparam logic [LFSR_WIDTH-1:0]  LFSR_SHORT_MASK = 15'h007F;
   localparam logic [5:0]             LENGTH_FULL   = 6'd63;
   localparam logic [3:0]             ENV_DEFAULT   = 4'd8;
   localparam logic [3:0]             VOLUME_MAX    = 4'd15;
   localparam logic [7:0]             READ_OPEN_BUS = 8'hFF;

   typedef logic [DIV_WIDTH-1:0] divisor_type;

   // Reset value of the divisor for a given divider code.
   function automatic divisor_type divisor_reset(input logic [2:0] code);
      divisor_type value;
      if (code == 3'd0) begin
         value = 8'd8;
      end else begin
         value = {1'b0, code, 4'b0000};
      end
      return value;
   endfunction

   // One LFSR clock: low-bit XOR enters the top, or bit 6 in short mode.
   function automatic logic [LFSR_WIDTH-1:0] lfsr_step(input logic [LFSR_WIDTH-1:0] sr,
                                                       input logic short_mode);
      logic                  fb;
      logic [LFSR_WIDTH-1:0] shifted;
      fb      = sr[0] ^ sr[1];
      shifted = sr >> 1;
      if (short_mode) begin
         shifted[6] = fb;
         shifted    = shifted & LFSR_SHORT_MASK;
      end else begin
         shifted[LFSR_WIDTH-1] = fb;
      end
      return shifted;
   endfunction

endpackage

>>> src/noise_channel_lfsr_envelope.sv
`timescale 1ns / 1ps

// Channel   Ports                                              Direction
// -------   -------------------------------------------------  ---------
// request   req_valid/req_ready, req_operation, req_reg_index,  in
//           req_write_data
// response  rsp_valid/rsp_ready, rsp_sample, rsp_read_data,     out
//           rsp_channel_on
// csr       csr_we, csr_index, csr_wdata (divisor table)        in
//
// Every accepted request word yields exactly one response word in the next cycle.
// The whole event update (timer, LFSR, length, envelope, register access) is
// one short combinational pass from the state registers into the next state and
// the response register, so one word per cycle is sustained while rsp_ready is high.
// The request side stays ready while the response register is empty or is
// being drained in the same cycle; a stalled response holds one word.
// Synchronous active-high reset clears the channel state and loads the default
// divisor table; power-off clears the same state but keeps the divisors.
module noise_channel_lfsr_envelope
   import nch_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [1:0] req_reg_index,
   input  logic [7:0] req_write_data,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_sample,
   output logic [7:0] rsp_read_data,
   output logic       rsp_channel_on,

   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // Channel state.
   logic [TIMER_WIDTH-1:0] freq_timer_ff, freq_timer_in;
   logic [LFSR_WIDTH-1:0]  shift_reg_ff, shift_reg_in;
   logic [5:0]             length_count_ff, length_count_in;
   logic                   length_enable_ff, length_enable_in;
   logic                   chan_enabled_ff, chan_enabled_in;
   logic                   dac_on_ff, dac_on_in;
   logic [2:0]             env_period_ff, env_period_in;
   logic                   env_up_ff, env_up_in;
   logic [3:0]             env_start_ff, env_start_in;
   logic [2:0]             divider_code_ff, divider_code_in;
   logic                   short_mode_ff, short_mode_in;
   logic [3:0]             shift_amount_ff, shift_amount_in;
   logic                   env_running_ff, env_running_in;
   logic [3:0]             env_timer_ff, env_timer_in;
   logic [3:0]             volume_ff, volume_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_sample_ff, rsp_sample_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_channel_on_ff, rsp_channel_on_in;

   logic                   accept;
   logic [TIMER_WIDTH-1:0] reload_value;
   logic [TIMER_WIDTH-1:0] timer_dec;
   logic [3:0]             env_dec;
   logic [3:0]             env_reload;
   logic [3:0]             vol_next;
   logic [7:0]             read_value;

   // The reload value always follows the currently stored divider code and
   // shift, which is what both the timer wrap and a trigger use.
   nch_divisors u_divisors (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .div_code     (divider_code_ff),
      .shift_amount (shift_amount_ff),
      .reload_value (reload_value)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign timer_dec  = freq_timer_ff - 1'b1;
   assign env_dec    = env_timer_ff - 1'b1;
   assign env_reload = (env_period_ff == 3'd0) ? ENV_DEFAULT : {1'b0, env_period_ff};

   always_comb begin
      freq_timer_in    = freq_timer_ff;
      shift_reg_in     = shift_reg_ff;
      length_count_in  = length_count_ff;
      length_enable_in = length_enable_ff;
      chan_enabled_in  = chan_enabled_ff;
      dac_on_in        = dac_on_ff;
      env_period_in    = env_period_ff;
      env_up_in        = env_up_ff;
      env_start_in     = env_start_ff;
      divider_code_in  = divider_code_ff;
      short_mode_in    = short_mode_ff;
      shift_amount_in  = shift_amount_ff;
      env_running_in   = env_running_ff;
      env_timer_in     = env_timer_ff;
      volume_in        = volume_ff;
      read_value       = READ_OPEN_BUS;
      vol_next         = volume_ff;

      if (accept) begin
         case (req_operation)
            OP_FREQ_TICK: begin
               // A timer already at zero wraps to all ones and does not reload.
               if (timer_dec == '0) begin
                  freq_timer_in = reload_value;
                  shift_reg_in  = lfsr_step(shift_reg_ff, short_mode_ff);
               end else begin
                  freq_timer_in = timer_dec;
               end
            end
            OP_LENGTH_TICK: begin
               if ((length_count_ff != 6'd0) && length_enable_ff) begin
                  length_count_in = length_count_ff - 1'b1;
                  if (length_count_ff == 6'd1) begin
                     chan_enabled_in = 1'b0;
                  end
               end
            end
            OP_ENV_TICK: begin
               if (env_dec == 4'd0) begin
                  env_timer_in = env_reload;
                  if (env_running_ff && (env_period_ff != 3'd0)) begin
                     if (env_up_ff) begin
                        if (volume_ff != VOLUME_MAX) begin
                           vol_next = volume_ff + 1'b1;
                        end
                     end else begin
                        if (volume_ff != 4'd0) begin
                           vol_next = volume_ff - 1'b1;
                        end
                     end
                  end
                  volume_in = vol_next;
                  // The envelope stops, until the next trigger, once it sits at either rail.
                  if ((vol_next == 4'd0) || (vol_next == VOLUME_MAX)) begin
                     env_running_in = 1'b0;
                  end
               end else begin
                  env_timer_in = env_dec;
               end
            end
            OP_WRITE: begin
               case (req_reg_index)
                  REG_LENGTH: begin
                     length_count_in = req_write_data[5:0];
                  end
                  REG_ENVELOPE: begin
                     env_period_in = req_write_data[2:0];
                     env_up_in     = req_write_data[3];
                     env_start_in  = req_write_data[7:4];
                     dac_on_in     = (req_write_data[7:4] != 4'd0) || req_write_data[3];
                  end
                  REG_POLY: begin
                     divider_code_in = req_write_data[2:0];
                     short_mode_in   = req_write_data[3];
                     shift_amount_in = req_write_data[7:4];
                  end
                  REG_CONTROL: begin
                     length_enable_in = req_write_data[6];
                     // Trigger restarts every sequencer of the channel.
                     if (req_write_data[7]) begin
                        chan_enabled_in = 1'b1;
                        if (length_count_ff == 6'd0) begin
                           length_count_in = LENGTH_FULL;
                        end
                        freq_timer_in  = reload_value;
                        env_running_in = (env_start_ff != 4'd0) || env_up_ff;
                        env_timer_in   = env_reload;
                        volume_in      = env_start_ff;
                        shift_reg_in   = LFSR_SEED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_READ: begin
               case (req_reg_index)
                  REG_ENVELOPE: read_value = {env_start_ff, env_up_ff, env_period_ff};
                  REG_POLY:     read_value = {shift_amount_ff, short_mode_ff, divider_code_ff};
                  default:      read_value = READ_OPEN_BUS;
               endcase
            end
            OP_POWER_OFF: begin
               freq_timer_in    = TIMER_RESET;
               shift_reg_in     = '0;
               length_count_in  = '0;
               length_enable_in = 1'b0;
               chan_enabled_in  = 1'b0;
               dac_on_in        = 1'b0;
               env_period_in    = '0;
               env_up_in        = 1'b0;
               env_start_in     = '0;
               divider_code_in  = '0;
               short_mode_in    = 1'b0;
               shift_amount_in  = '0;
               env_running_in   = 1'b0;
               env_timer_in     = '0;
               volume_in        = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // The response word reflects the state after the event.
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_in     = rsp_sample_ff;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_channel_on_in = rsp_channel_on_ff;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_sample_in     = (chan_enabled_in && dac_on_in && !shift_reg_in[0]) ?
                             volume_in : 4'd0;
         rsp_read_data_in  = read_value;
         rsp_channel_on_in = chan_enabled_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_timer_ff    <= TIMER_RESET;
         shift_reg_ff     <= '0;
         length_count_ff  <= '0;
         length_enable_ff <= 1'b0;
         chan_enabled_ff  <= 1'b0;
         dac_on_ff        <= 1'b0;
         env_period_ff    <= '0;
         env_up_ff        <= 1'b0;
         env_start_ff     <= '0;
         divider_code_ff  <= '0;
         short_mode_ff    <= 1'b0;
         shift_amount_ff  <= '0;
         env_running_ff   <= 1'b0;
         env_timer_ff     <= '0;
         volume_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         freq_timer_ff    <= freq_timer_in;
         shift_reg_ff     <= shift_reg_in;
         length_count_ff  <= length_count_in;
         length_enable_ff <= length_enable_in;
         chan_enabled_ff  <= chan_enabled_in;
         dac_on_ff        <= dac_on_in;
         env_period_ff    <= env_period_in;
         env_up_ff        <= env_up_in;
         env_start_ff     <= env_start_in;
         divider_code_ff  <= divider_code_in;
         short_mode_ff    <= short_mode_in;
         shift_amount_ff  <= shift_amount_in;
         env_running_ff   <= env_running_in;
         env_timer_ff     <= env_timer_in;
         volume_ff        <= volume_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff     <= rsp_sample_in;
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_channel_on_ff <= rsp_channel_on_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_channel_on = rsp_channel_on_ff;

   // A silent channel never shows a nonzero level.
   a_off_is_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_channel_on_ff |-> rsp_sample_ff == 4'd0)
      else $error("channel off but sample nonzero");

   // Only register reads drive anything but open bus on the read data.
   a_non_read_open_bus: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation != OP_READ) |=> rsp_read_data_ff == READ_OPEN_BUS)
      else $error("non-read word returned read data");

   // Power-off always leaves the channel disabled in its response.
   a_power_off: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_POWER_OFF) |=> !rsp_channel_on_ff && rsp_valid_ff)
      else $error("power-off left channel on");

   // An empty response register never stalls the request side.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with empty response register");

   // Every accepted word produces a response word in the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

endmodule

>>> src/nch_divisors.sv
`timescale 1ns / 1ps

// Divisor table written through the configuration port, and the timer reload
// value it produces for the selected divider code and shift.
module nch_divisors
   import nch_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [DIV_WIDTH-1:0]   csr_wdata,
   input  logic [2:0]             div_code,
   input  logic [SHIFT_WIDTH-1:0] shift_amount,
   output logic [TIMER_WIDTH-1:0] reload_value
);

   divisor_type div_ff [DIV_COUNT];

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_COUNT; i++) begin
         if (reset) begin
            div_ff[i] <= divisor_reset(3'(i));
         end else if (csr_we && (csr_index == 3'(i))) begin
            div_ff[i] <= csr_wdata;
         end
      end
   end

   // An 8-bit divisor shifted by at most 15 fits the 23-bit timer exactly.
   assign reload_value = {{(TIMER_WIDTH-DIV_WIDTH){1'b0}}, div_ff[div_code]} << shift_amount;

endmodule

>>> verif/tb_noise_channel_lfsr_envelope.sv
`timescale 1ns / 1ps

// Testbench for the noise channel. Every request word is one channel event:
// a frequency, length or envelope tick, a register write or read, or
// power-off. The channel answers each word with exactly one output word that
// carries the sample level, the read data and the on flag. A copy of the
// channel state is kept here and advanced for every accepted request word.
// The output word that this copy predicts is queued, and the output monitor
// compares each word that the channel hands over with the oldest queued one.
module tb_noise_channel_lfsr_envelope;
   import nch_pkg::*;

   // The operation field is three bits wide, so codes 6 and 7 can be sent.
   // The channel must treat them as no-ops that still answer with a word.
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   // Bits of the control register byte.
   localparam logic [7:0] CTRL_TRIGGER    = 8'h80;
   localparam logic [7:0] CTRL_LENGTH_ENA = 8'h40;

   localparam int unsigned RUN_LIMIT_NS = 2_000_000;
   localparam int unsigned DRAIN_LIMIT  = 10_000;

   typedef struct packed {
      logic [3:0] sample;
      logic [7:0] read_data;
      logic       channel_on;
   } channel_word_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [2:0] req_operation  = OP_FREQ_TICK;
   logic [1:0] req_reg_index  = REG_LENGTH;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b1;
   logic [3:0] rsp_sample;
   logic [7:0] rsp_read_data;
   logic       rsp_channel_on;
   logic       csr_we         = 1'b0;
   logic [2:0] csr_index      = 3'd0;
   logic [7:0] csr_wdata      = 8'h00;

   noise_channel_lfsr_envelope uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_read_data  (rsp_read_data),
      .rsp_channel_on (rsp_channel_on),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Output words that the channel still owes, oldest first.
   channel_word_type pending_channel_words[$];
   int            error_count    = 0;

   // Percentages of cycles in which the sender holds back a word and in
   // which the receiver refuses one. Each test phase sets them.
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_stall_pct = 0;

   // Predicted channel state, kept at the widths of the hardware.
   logic [7:0]             div_table [DIV_COUNT];
   logic [TIMER_WIDTH-1:0] ch_timer;
   logic [LFSR_WIDTH-1:0]  ch_lfsr;
   logic [5:0]             ch_length;
   logic                   ch_length_ena;
   logic                   ch_on;
   logic                   ch_dac;
   logic [2:0]             ch_env_period;
   logic                   ch_env_up;
   logic [3:0]             ch_env_start;
   logic [2:0]             ch_div_code;
   logic                   ch_short;
   logic [3:0]             ch_shift;
   logic                   ch_env_active;
   logic [3:0]             ch_env_count;
   logic [3:0]             ch_volume;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Power-off and reset both bring the channel back to this state. Only
   // reset restores the divisor table.
   function automatic void clear_channel_state();
      ch_timer      = TIMER_RESET;
      ch_lfsr       = '0;
      ch_length     = '0;
      ch_length_ena = 1'b0;
      ch_on         = 1'b0;
      ch_dac        = 1'b0;
      ch_env_period = '0;
      ch_env_up     = 1'b0;
      ch_env_start  = '0;
      ch_div_code   = '0;
      ch_short      = 1'b0;
      ch_shift      = '0;
      ch_env_active = 1'b0;
      ch_env_count  = '0;
      ch_volume     = '0;
   endfunction

   // The timer period is the divisor of the current code shifted left. Only
   // the low 23 bits are kept.
   function automatic logic [TIMER_WIDTH-1:0] timer_period();
      logic [TIMER_WIDTH-1:0] base;
      base = TIMER_WIDTH'(div_table[ch_div_code]);
      return base << ch_shift;
   endfunction

   // Applies one event to the predicted state and returns the output word
   // that the channel must produce for it.
   function automatic channel_word_type advance_channel(input logic [2:0] op,
                                                        input logic [1:0] idx,
                                                        input logic [7:0] data);
      channel_word_type      word;
      logic                  feedback;
      logic [LFSR_WIDTH-1:0] shifted;
      word.read_data = READ_OPEN_BUS;
      case (op)
         OP_FREQ_TICK: begin
            // A timer that reaches zero reloads and clocks the LFSR once.
            ch_timer = ch_timer - 1'b1;
            if (ch_timer == '0) begin
               ch_timer = timer_period();
               feedback = ch_lfsr[1] ^ ch_lfsr[0];
               shifted  = ch_lfsr >> 1;
               if (ch_short) begin
                  // Seven-bit mode feeds bit 6 and drops everything above it.
                  shifted = {8'h00, feedback, shifted[5:0]};
               end else begin
                  shifted[LFSR_WIDTH-1] = feedback;
               end
               ch_lfsr = shifted;
            end
         end
         OP_LENGTH_TICK: begin
            if (ch_length != '0 && ch_length_ena) begin
               ch_length = ch_length - 1'b1;
               if (ch_length == '0) begin
                  ch_on = 1'b0;
               end
            end
         end
         OP_ENV_TICK: begin
            // The envelope counter wraps from zero to 15. When it reaches
            // zero it reloads, and a period of zero reloads with 8.
            ch_env_count = ch_env_count - 1'b1;
            if (ch_env_count == '0) begin
               ch_env_count = (ch_env_period != '0) ? {1'b0, ch_env_period} : ENV_DEFAULT;
               if (ch_env_active && ch_env_period != '0) begin
                  if (ch_env_up && ch_volume != VOLUME_MAX) begin
                     ch_volume = ch_volume + 1'b1;
                  end else if (!ch_env_up && ch_volume != '0) begin
                     ch_volume = ch_volume - 1'b1;
                  end
               end
               if (ch_volume == '0 || ch_volume == VOLUME_MAX) begin
                  ch_env_active = 1'b0;
               end
            end
         end
         OP_WRITE: begin
            case (idx)
               REG_LENGTH: begin
                  ch_length = data[5:0];
               end
               REG_ENVELOPE: begin
                  ch_env_period = data[2:0];
                  ch_env_up     = data[3];
                  ch_env_start  = data[7:4];
                  ch_dac        = (data[7:4] != '0) || data[3];
               end
               REG_POLY: begin
                  ch_div_code = data[2:0];
                  ch_short    = data[3];
                  ch_shift    = data[7:4];
               end
               default: begin
                  ch_length_ena = data[6];
                  if (data[7]) begin
                     // Trigger: the channel restarts from its programmed setup.
                     ch_on = 1'b1;
                     if (ch_length == '0) begin
                        ch_length = LENGTH_FULL;
                     end
                     ch_timer      = timer_period();
                     ch_env_active = (ch_env_start != '0) || ch_env_up;
                     ch_env_count  = (ch_env_period != '0) ? {1'b0, ch_env_period}
                                                           : ENV_DEFAULT;
                     ch_volume     = ch_env_start;
                     ch_lfsr       = LFSR_SEED;
                  end
               end
            endcase
         end
         OP_READ: begin
            if (idx == REG_ENVELOPE) begin
               word.read_data = {ch_env_start, ch_env_up, ch_env_period};
            end else if (idx == REG_POLY) begin
               word.read_data = {ch_shift, ch_short, ch_div_code};
            end
         end
         OP_POWER_OFF: begin
            clear_channel_state();
         end
         default: begin
         end
      endcase
      // The level is heard only when the channel and its DAC are on and the
      // LFSR output bit is low.
      word.sample     = (ch_on && ch_dac && !ch_lfsr[0]) ? ch_volume : 4'h0;
      word.channel_on = ch_on;
      return word;
   endfunction

   // The receiver refuses words at random in the share of cycles that the
   // phase asks for.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Output monitor: every word that the channel hands over must match the
   // oldest prediction.
   always @(posedge clock) begin : check_output_words
      channel_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_channel_words.size() == 0) begin
            $error("output word with none expected: sample %0d read_data 0x%02h channel_on %0b",
                   rsp_sample, rsp_read_data, rsp_channel_on);
            error_count++;
         end else begin
            want = pending_channel_words.pop_front();
            if (rsp_sample !== want.sample) begin
               $error("sample: expected %0d, actual %0d", want.sample, rsp_sample);
               error_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected 0x%02h, actual 0x%02h",
                      want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_channel_on !== want.channel_on) begin
               $error("channel_on: expected %0b, actual %0b",
                      want.channel_on, rsp_channel_on);
               error_count++;
            end
         end
      end
   end

   // Sends one request word. It is entered and left at a falling edge. Before
   // the word, the sender may sit idle for a random number of cycles.
   task automatic send_event(input logic [2:0] op, input logic [1:0] idx,
                             input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_operation  <= op;
      req_reg_index  <= idx;
      req_write_data <= data;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_channel_words.push_back(advance_channel(op, idx, data));
      @(negedge clock);
   endtask

   // Stops sending and waits until the channel has delivered every word that
   // it owes. The channel is idle afterwards.
   task automatic settle_channel();
      req_valid <= 1'b0;
      while (pending_channel_words.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   // Loads all eight divisors, one per cycle. Byte i of the argument goes to
   // divider code i. Only called while the channel is idle.
   task automatic write_divisor_table(input logic [63:0] divisors);
      for (int code = 0; code < DIV_COUNT; code++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(code);
         csr_wdata <= divisors[8*code +: 8];
         div_table[code] = divisors[8*code +: 8];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Ticks of every kind before the first trigger, and the two unused
   // codes. The first envelope tick finds its counter at zero, so the
   // counter wraps to 15.
   task automatic test_idle_events();
      send_event(OP_ENV_TICK, REG_LENGTH, 8'h00);
      send_event(OP_FREQ_TICK, REG_LENGTH, 8'h00);
      send_event(OP_LENGTH_TICK, REG_LENGTH, 8'h00);
      send_event(OP_UNUSED_6, REG_CONTROL, 8'hFF);
      send_event(OP_UNUSED_7, REG_POLY, 8'hA5);
   endtask

   // The two registers without read-back return all ones. The other two
   // return what was written, here with every bit set.
   task automatic test_register_map();
      send_event(OP_READ, REG_LENGTH, 8'h00);
      send_event(OP_READ, REG_CONTROL, 8'h00);
      send_event(OP_WRITE, REG_ENVELOPE, 8'hFF);
      send_event(OP_READ, REG_ENVELOPE, 8'h00);
      send_event(OP_WRITE, REG_POLY, 8'hFF);
      send_event(OP_READ, REG_POLY, 8'h00);
   endtask

   // Divider code 0 has divisor 1, so every frequency tick clocks the LFSR.
   // The LFSR runs in seven-bit mode from the all-ones seed. A zero length
   // becomes the full count at trigger.
   task automatic test_trigger_and_lfsr();
      send_event(OP_WRITE, REG_POLY, 8'h08);
      send_event(OP_WRITE, REG_ENVELOPE, 8'hF1);
      send_event(OP_WRITE, REG_LENGTH, 8'h00);
      send_event(OP_WRITE, REG_CONTROL, CTRL_TRIGGER | CTRL_LENGTH_ENA);
      repeat (3) send_event(OP_FREQ_TICK, REG_LENGTH, 8'h00);
   endtask

   // With a period of 1, each envelope tick lowers the volume by one step.
   task automatic test_envelope_steps();
      repeat (2) send_event(OP_ENV_TICK, REG_LENGTH, 8'h00);
   endtask

   // A length of 1 runs out on the next length tick and turns the channel off.
   task automatic test_length_expiry();
      send_event(OP_WRITE, REG_LENGTH, 8'h01);
      send_event(OP_LENGTH_TICK, REG_LENGTH, 8'h00);
   endtask

   // Power-off clears the channel registers, so a read of the poly register
   // returns zero.
   task automatic test_power_off();
      send_event(OP_POWER_OFF, REG_LENGTH, 8'h00);
      send_event(OP_READ, REG_POLY, 8'h00);
   endtask

   // Envelope setup biased toward start volumes near the clamps and short
   // periods, so that the volume reaches 0 or 15 within one burst.
   function automatic logic [7:0] pick_envelope_byte();
      logic [3:0] start_vol;
      logic [2:0] period;
      if ($urandom_range(1) == 0) begin
         start_vol = 4'($urandom);
      end else if ($urandom_range(1) == 0) begin
         start_vol = 4'($urandom_range(0, 2));
      end else begin
         start_vol = 4'($urandom_range(13, 15));
      end
      period = ($urandom_range(1) == 0) ? 3'd1 : 3'($urandom);
      return {start_vol, 1'($urandom), period};
   endfunction

   // Poly setup. Small shifts keep the timer short enough for the LFSR to
   // move, and now and then any shift up to 15 is used.
   function automatic logic [7:0] pick_poly_byte();
      logic [3:0] shift;
      shift = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1));
      return {shift, 1'($urandom), 3'($urandom)};
   endfunction

   // Event mix inside a burst. Frequency ticks dominate so that the LFSR
   // moves. Power-off is rare because it ends the useful part of a burst.
   function automatic logic [2:0] pick_burst_op();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return OP_FREQ_TICK;
      if (roll < 58) return OP_LENGTH_TICK;
      if (roll < 78) return OP_ENV_TICK;
      if (roll < 90) return OP_READ;
      if (roll < 96) return OP_WRITE;
      if (roll < 97) return OP_POWER_OFF;
      return ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
   endfunction

   // One random phase. Most of the traffic programs the channel, triggers it
   // and then runs a burst of events. The rest is single random words. Now
   // and then the sender waits until the channel has caught up.
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input logic [63:0] divisors,
                                      input int unsigned word_count);
      int unsigned sent;
      logic [2:0]  op;
      settle_channel();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_divisor_table(divisors);
      sent = 0;
      while (sent < word_count) begin
         if ($urandom_range(99) < 80) begin
            send_event(OP_WRITE, REG_ENVELOPE, pick_envelope_byte());
            send_event(OP_WRITE, REG_POLY, pick_poly_byte());
            // Short lengths make the length counter expire within a burst.
            send_event(OP_WRITE, REG_LENGTH,
                       {2'($urandom), ($urandom_range(1) == 0) ? 6'($urandom_range(3))
                                                               : 6'($urandom)});
            send_event(OP_WRITE, REG_CONTROL, CTRL_TRIGGER | 8'($urandom_range(127)));
            sent += 4;
            repeat ($urandom_range(8, 48)) begin
               op = pick_burst_op();
               send_event(op, 2'($urandom), 8'($urandom));
               if (op != OP_UNUSED_6 && op != OP_UNUSED_7) begin
                  sent++;
               end
            end
         end else begin
            op = 3'($urandom);
            send_event(op, 2'($urandom), 8'($urandom));
            if (op != OP_UNUSED_6 && op != OP_UNUSED_7) begin
               sent++;
            end
         end
         if ($urandom_range(99) < 3) begin
            settle_channel();
         end
      end
   endtask

   initial begin : run_tests
      logic [63:0] mixed_divisors;
      int unsigned drain_cycles;
      for (int code = 0; code < DIV_COUNT; code++) begin
         div_table[code] = (code == 0) ? 8'd8 : 8'(16 * code);
      end
      clear_channel_state();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The directed words run with no idling on either side.
      write_divisor_table(64'hFF07_0605_0403_0201);
      test_idle_events();
      test_register_map();
      test_trigger_and_lfsr();
      test_envelope_steps();
      test_length_expiry();
      test_power_off();

      // Random phases. The divisor tables go from all minimum to small values mixed
      // with maximum, to minimum and maximum alternating, then to random small values.
      for (int code = 0; code < DIV_COUNT; code++) begin
         mixed_divisors[8*code +: 8] = 8'($urandom_range(1, 4));
      end
      test_random_traffic(0, 0, 64'h0101_0101_0101_0101, 200);
      test_random_traffic(71, 0, 64'h03FF_0201_FF02_0301, 200);
      test_random_traffic(0, 71, 64'hFF01_FF01_FF01_FF01, 200);
      test_random_traffic(33, 33, mixed_divisors, 200);

      // Wait for the channel to finish delivering words, then give it some
      // further cycles so that any extra output word gets caught.
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (pending_channel_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      if (pending_channel_words.size() != 0) begin
         $error("%0d expected output words never arrived", pending_channel_words.size());
         error_count++;
      end
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // If the channel hangs, the run still ends, and it ends as a failure.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/nch_pkg.sv
src/nch_divisors.sv
src/noise_channel_lfsr_envelope.sv
verif/tb_noise_channel_lfsr_envelope.sv
